// ===== rtl/firv_pkg.sv =====
// ----------------------------------------------------------------------------
// firv_pkg
// Types and constants shared by the frame index record validator.
// ----------------------------------------------------------------------------
`default_nettype none

package firv_pkg;

   localparam int MAX_RECORDS = 4096;
   localparam int SPAN_CAP    = 1152;

   localparam logic [1:0] ST_RUNNING   = 2'd0;
   localparam logic [1:0] ST_VALID     = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   localparam logic [1:0] REG_REC_TOTAL   = 2'd0;
   localparam logic [1:0] REG_ASSET_BYTES = 2'd1;
   localparam logic [1:0] REG_EXP_FRAMES  = 2'd2;
   localparam logic [1:0] REG_BYTE_LIMIT  = 2'd3;

   typedef struct packed {
      logic [31:0] record_byte_offset;
      logic [31:0] record_byte_length;
      logic [31:0] record_position;
   } firv_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] record_number;
      logic [15:0] max_frame_bytes;
      logic [10:0] max_frame_span;
   } firv_rsp_type;

   typedef struct packed {
      logic [15:0] rec_total;
      logic [31:0] asset_byte_length;
      logic [31:0] expected_frames;
      logic [15:0] frame_byte_limit;
   } firv_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/firv_csr.sv =====
// ----------------------------------------------------------------------------
// firv_csr
// APB-style register file holding the index configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module firv_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [3:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output firv_pkg::firv_cfg_type     cfg
);
   import firv_pkg::*;

   firv_cfg_type cfg_ff, cfg_in;
   logic         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_REC_TOTAL:   cfg_in.rec_total         = pwdata[15:0];
            REG_ASSET_BYTES: cfg_in.asset_byte_length = pwdata;
            REG_EXP_FRAMES:  cfg_in.expected_frames   = pwdata;
            REG_BYTE_LIMIT:  cfg_in.frame_byte_limit  = pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_REC_TOTAL:   prdata = {16'd0, cfg_ff.rec_total};
         REG_ASSET_BYTES: prdata = cfg_ff.asset_byte_length;
         REG_EXP_FRAMES:  prdata = cfg_ff.expected_frames;
         REG_BYTE_LIMIT:  prdata = {16'd0, cfg_ff.frame_byte_limit};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rec_total         <= 16'd1;
         cfg_ff.asset_byte_length <= 32'd0;
         cfg_ff.expected_frames   <= 32'd1;
         cfg_ff.frame_byte_limit  <= 16'd2048;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/firv_check.sv =====
// ----------------------------------------------------------------------------
// firv_check
// Per-record checks against the held previous record, sticky error and maxima.
// ----------------------------------------------------------------------------
`default_nettype none

module firv_check (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire firv_pkg::firv_req_type rec,
   input  wire firv_pkg::firv_cfg_type cfg,
   output firv_pkg::firv_rsp_type     result
);
   import firv_pkg::*;

   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] pend_pos_ff, pend_pos_in;
   logic [32:0] pend_be_ff, pend_be_in;
   logic [15:0] lg_bytes_ff, lg_bytes_in;
   logic [10:0] lg_span_ff, lg_span_in;
   logic        err_ff, err_in;
   logic [1:0]  code_ff, code_in;

   logic        cnt_bad, last, first, too_large, rec_bad;
   logic [32:0] rec_end;
   logic [31:0] span1, span2;
   logic        span1_ok, span2_ok;
   logic [10:0] ls1, ls2;
   logic [1:0]  status;

   assign cnt_bad  = (cfg.rec_total == 16'd0) ||
                     (cfg.rec_total > 16'(MAX_RECORDS));
   assign last     = (cfg.rec_total == 16'd0) ||
                     (cnt_ff == cfg.rec_total - 16'd1);
   assign first    = (cnt_ff == 16'd0);
   assign rec_end  = {1'b0, rec.record_byte_offset} + {1'b0, rec.record_byte_length};
   assign too_large = rec.record_byte_length > {16'd0, cfg.frame_byte_limit};
   assign rec_bad  = (rec.record_byte_length == 32'd0) || too_large ||
                     (rec_end > {1'b0, cfg.asset_byte_length}) ||
                     (!first && ((rec.record_position <= pend_pos_ff) ||
                                 ({1'b0, rec.record_byte_offset} < pend_be_ff)));

   // span of the held record, closed by this record's position
   assign span1    = rec.record_position - pend_pos_ff;
   assign span1_ok = (rec.record_position > pend_pos_ff) &&
                     (rec.record_position <= cfg.expected_frames) &&
                     (span1 <= 32'(SPAN_CAP));
   // span of this record when it closes the index
   assign span2    = cfg.expected_frames - rec.record_position;
   assign span2_ok = (cfg.expected_frames > rec.record_position) &&
                     (span2 <= 32'(SPAN_CAP));

   assign ls1 = (!first && (span1[10:0] > lg_span_ff)) ? span1[10:0] : lg_span_ff;
   assign ls2 = (last && (span2[10:0] > ls1)) ? span2[10:0] : ls1;

   always_comb begin
      err_in      = err_ff;
      code_in     = code_ff;
      pend_pos_in = pend_pos_ff;
      pend_be_in  = pend_be_ff;
      lg_bytes_in = lg_bytes_ff;
      lg_span_in  = lg_span_ff;
      if (!err_ff) begin
         if (cnt_bad || (!first && !span1_ok) ||
             (first && (rec.record_position != 32'd0))) begin
            err_in  = 1'b1;
            code_in = ST_INVALID;
         end else if (rec_bad) begin
            err_in  = 1'b1;
            code_in = too_large ? ST_TOO_LARGE : ST_INVALID;
         end else begin
            pend_pos_in = rec.record_position;
            pend_be_in  = rec_end;
            lg_span_in  = ls2;
            if (rec.record_byte_length[15:0] > lg_bytes_ff) begin
               lg_bytes_in = rec.record_byte_length[15:0];
            end
            if (last && !span2_ok) begin
               err_in  = 1'b1;
               code_in = ST_INVALID;
            end
         end
      end
      cnt_in = cnt_ff + 16'd1;
   end

   assign status = err_in ? code_in : (last ? ST_VALID : ST_RUNNING);

   always_comb begin
      result.status          = status;
      result.record_number   = cnt_ff;
      result.max_frame_bytes = (status == ST_VALID) ? lg_bytes_in : 16'd0;
      result.max_frame_span  = (status == ST_VALID) ? lg_span_in : 11'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= 16'd0;
         pend_pos_ff <= 32'd0;
         pend_be_ff  <= 33'd0;
         lg_bytes_ff <= 16'd0;
         lg_span_ff  <= 11'd0;
         err_ff      <= 1'b0;
         code_ff     <= ST_RUNNING;
      end else if (advance) begin
         if (last) begin
            cnt_ff      <= 16'd0;
            pend_pos_ff <= 32'd0;
            pend_be_ff  <= 33'd0;
            lg_bytes_ff <= 16'd0;
            lg_span_ff  <= 11'd0;
            err_ff      <= 1'b0;
            code_ff     <= ST_RUNNING;
         end else begin
            cnt_ff      <= cnt_in;
            pend_pos_ff <= pend_pos_in;
            pend_be_ff  <= pend_be_in;
            lg_bytes_ff <= lg_bytes_in;
            lg_span_ff  <= lg_span_in;
            err_ff      <= err_in;
            code_ff     <= code_in;
         end
      end
   end

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && !last |=> cnt_ff == $past(cnt_ff) + 16'd1)
      else $error("record counter did not step");

   a_err_mid_index: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> cnt_ff != 16'd0)
      else $error("sticky error held at start of index");

   a_valid_on_last: assert property (@(posedge clock) disable iff (reset)
      result.status == ST_VALID |-> last && !err_ff)
      else $error("valid verdict before end of index");

endmodule

`default_nettype wire

// ===== rtl/frame_index_record_validator.sv =====
// ----------------------------------------------------------------------------
// frame_index_record_validator
// Seek index record checker: one record word in, one verdict word out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  firv_req_type record word
//  rsp      out        rsp_valid / rsp_stall  firv_rsp_type verdict word
//  csr      in/out     psel/penable/pready    32-bit registers at 4*i
//
//  One word per cycle sustained while rsp is not stalled.
//  Input register -> checks -> result register; state updates on the move.
//  Reset is synchronous and returns the valid flags, check state and registers
//  at 4*i to their defaults; the record and result registers are not reset.
//  A stalled rsp holds the result; req stalls only when both stages are full.
`default_nettype none

module frame_index_record_validator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire firv_pkg::firv_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output firv_pkg::firv_rsp_type      rsp_data,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [3:0]             paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import firv_pkg::*;

   firv_cfg_type cfg;
   firv_req_type rec_ff;
   firv_rsp_type result, rsp_ff;
   logic         s1_valid_ff, s1_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_adv, advance, req_take;

   firv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   firv_check u_check (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rec     (rec_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_adv;
   assign req_stall = s1_valid_ff && !out_adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_adv);
   assign rsp_valid_in = advance || (rsp_valid_ff && !out_adv);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rec_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_adv |-> req_stall)
      else $error("input word taken while pipeline blocked");

   a_result_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("checked word lost before result register");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_adv |=> s1_valid_ff && $stable(rec_ff))
      else $error("blocked input word changed");

endmodule

`default_nettype wire
